### rtl/ffpra_pkg.sv
// Shared types, codes and widths for the first-fit page run allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ffpra_pkg;

   localparam int NUM_PAGES_DEF  = 1024;
   localparam int PAGE_SHIFT_DEF = 12;

   localparam int ADDR_W      = 56;
   localparam int PAGE_CNT_W  = 11;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_IDX_W   = 1;

   typedef logic [1:0] page_state_type;
   localparam page_state_type PG_FREE  = 2'd0;
   localparam page_state_type PG_TAKEN = 2'd1;
   localparam page_state_type PG_LAST  = 2'd2;

   typedef logic [1:0] rsp_status_type;
   localparam rsp_status_type STAT_DONE   = 2'd0;
   localparam rsp_status_type STAT_NOROOM = 2'd1;
   localparam rsp_status_type STAT_BAD    = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_IN_USE = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_MARK,
      S_WALK,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic           clr_step;
      logic           load;
      logic           scan_start;
      logic           scan_step;
      logic           mark_step;
      logic           walk_start;
      logic           walk_step;
      logic           out_load;
      rsp_status_type res_status;
      logic           res_addr_ok;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mode;
      logic want_zero;
      logic n_zero;
      logic free_bad;
      logic scan_found;
      logic scan_end;
      logic mark_last;
      logic walk_stop;
      logic out_full;
   } dp_sts_type;

endpackage

`default_nettype wire

### rtl/first_fit_page_run_allocator_top.sv
// Allocate: check, then a scan of k entries (at most the pages in use, one per cycle
// through the status memory read port) and r pages marked, one write a cycle; free:
// check, then a walk of w pages; rejects go from the check straight to the result.
// Throughput: one word at a time; the next word is taken once the result is queued.
// Reset: synchronous; then a clearing pass over every page with req_tready low.
`default_nettype none

module first_fit_page_run_allocator_top #(
   parameter int NUM_PAGES  = ffpra_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = ffpra_pkg::PAGE_SHIFT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ffpra_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ffpra_pkg::ADDR_W-1:0]      csr_data,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // request_pages[10:0], free_address[66:11], zero fill[71:67]
   input  wire logic [ffpra_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode[0]
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // run_address[55:0]
   output logic [ffpra_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // status[1:0]
   output logic [1:0]                             rsp_tuser
);
   import ffpra_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   ffpra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffpra_dp #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/ffpra_ctrl.sv
// Sequencer of the page run allocator: clear pass, request checks, scan, mark, walk.
// Depends on ffpra_pkg; drives ffpra_dp through dp_cmd_type.
`default_nettype none

module ffpra_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire ffpra_pkg::dp_sts_type sts,
   output ffpra_pkg::dp_cmd_type      cmd
);
   import ffpra_pkg::*;

   ctrl_state_type state_ff, state_in;
   rsp_status_type res_ff, res_in;
   logic           addr_ok_ff, addr_ok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      addr_ok_ff <= addr_ok_in;
   end

   always_comb begin
      state_in   = state_ff;
      res_in     = res_ff;
      addr_ok_in = addr_ok_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.res_status  = res_ff;
      cmd.res_addr_ok = addr_ok_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            addr_ok_in = 1'b0;
            if (sts.mode == MODE_ALLOC) begin
               if (sts.want_zero) begin
                  res_in   = STAT_BAD;
                  state_in = S_FINISH;
               end else if (sts.n_zero) begin
                  res_in   = STAT_NOROOM;
                  state_in = S_FINISH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end else begin
               if (sts.free_bad) begin
                  res_in   = STAT_BAD;
                  state_in = S_FINISH;
               end else begin
                  cmd.walk_start = 1'b1;
                  state_in       = S_WALK;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_found) begin
               res_in     = STAT_DONE;
               addr_ok_in = 1'b1;
               state_in   = S_MARK;
            end else if (sts.scan_end) begin
               res_in   = STAT_NOROOM;
               state_in = S_FINISH;
            end
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.mark_last) begin
               state_in = S_FINISH;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_stop) begin
               res_in   = STAT_DONE;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/ffpra_dp.sv
// Datapath of the page run allocator: config registers, page status memory,
// scan and walk counters, address math and the result register. Uses ffpra_pkg.
`default_nettype none

module ffpra_dp #(
   parameter int NUM_PAGES  = ffpra_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = ffpra_pkg::PAGE_SHIFT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ffpra_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ffpra_pkg::ADDR_W-1:0]        csr_data,
   input  wire logic [ffpra_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                                req_tuser,
   input  wire ffpra_pkg::dp_cmd_type               cmd,
   output ffpra_pkg::dp_sts_type                    sts,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [ffpra_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [1:0]                               rsp_tuser
);
   import ffpra_pkg::*;

   localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int CNT_W = $clog2(NUM_PAGES + 1);
   localparam int CMP_W = (CNT_W > PAGE_CNT_W) ? CNT_W : PAGE_CNT_W;
   localparam int PG_W  = ADDR_W - PAGE_SHIFT;

   logic [ADDR_W-1:0]     base_ff;
   logic [PAGE_CNT_W-1:0] piu_ff;
   logic                  mode_ff;
   logic [PAGE_CNT_W-1:0] want_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      run_ff, run_in;
   logic [IDX_W-1:0]      start_ff, start_in;
   logic [IDX_W-1:0]      mark_ff, mark_in;
   page_state_type        rd_data_ff;
   logic                  rsp_tvalid_ff;
   rsp_status_type        rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;

   page_state_type        mem [NUM_PAGES];

   logic [CMP_W-1:0]      n_cmp;
   logic [CNT_W-1:0]      n;
   logic [CNT_W-1:0]      run_next;
   logic [CNT_W-1:0]      idx_inc;
   logic [CNT_W-1:0]      run_start;
   logic                  found;
   logic                  at_end;
   logic [ADDR_W-1:0]     diff;
   logic [PG_W-1:0]       pg;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   page_state_type        wr_data;
   logic [ADDR_W-1:0]     run_addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         piu_ff  <= PAGE_CNT_W'(1024);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REGION_BASE:  base_ff <= csr_data;
            CSR_PAGES_IN_USE: piu_ff  <= csr_data[PAGE_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tuser;
         want_ff <= req_tdata[PAGE_CNT_W-1:0];
         addr_ff <= req_tdata[PAGE_CNT_W +: ADDR_W];
      end
   end

   always_comb begin
      n_cmp = (CMP_W'(piu_ff) > CMP_W'(NUM_PAGES)) ? CMP_W'(NUM_PAGES) : CMP_W'(piu_ff);
      n     = n_cmp[CNT_W-1:0];

      run_next  = (rd_data_ff == PG_FREE) ? run_ff + CNT_W'(1) : '0;
      found     = (CMP_W'(run_next) == CMP_W'(want_ff));
      idx_inc   = CNT_W'(idx_ff) + CNT_W'(1);
      at_end    = (idx_inc == n);
      run_start = idx_inc - run_next;

      diff = addr_ff - base_ff;
      pg   = diff[ADDR_W-1:PAGE_SHIFT];

      run_addr = base_ff + (ADDR_W'(start_ff) << PAGE_SHIFT);
   end

   always_comb begin
      sts.clr_last   = (idx_ff == IDX_W'(NUM_PAGES - 1));
      sts.mode       = mode_ff;
      sts.want_zero  = (want_ff == '0);
      sts.n_zero     = (n == '0);
      sts.free_bad   = (addr_ff < base_ff) || (pg >= PG_W'(n));
      sts.scan_found = found;
      sts.scan_end   = at_end;
      sts.mark_last  = (mark_ff == idx_ff);
      sts.walk_stop  = (rd_data_ff != PG_TAKEN) || at_end;
      sts.out_full   = rsp_tvalid_ff && !rsp_tready;
   end

   always_comb begin
      idx_in   = idx_ff;
      run_in   = run_ff;
      start_in = start_ff;
      mark_in  = mark_ff;
      rd_addr  = idx_ff + IDX_W'(1);
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = PG_FREE;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_data = (idx_ff == '0) ? PG_LAST : PG_FREE;
         idx_in  = idx_ff + IDX_W'(1);
      end
      if (cmd.scan_start) begin
         idx_in  = '0;
         run_in  = '0;
         rd_addr = '0;
      end
      if (cmd.scan_step) begin
         run_in = run_next;
         if (found) begin
            start_in = run_start[IDX_W-1:0];
            mark_in  = run_start[IDX_W-1:0];
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
      if (cmd.mark_step) begin
         wr_en   = 1'b1;
         wr_addr = mark_ff;
         wr_data = (mark_ff == idx_ff) ? PG_LAST : PG_TAKEN;
         mark_in = mark_ff + IDX_W'(1);
      end
      if (cmd.walk_start) begin
         idx_in  = pg[IDX_W-1:0];
         rd_addr = pg[IDX_W-1:0];
      end
      if (cmd.walk_step) begin
         wr_en   = 1'b1;
         wr_data = PG_FREE;
         idx_in  = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff   <= run_in;
      start_ff <= start_in;
      mark_ff  <= mark_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.res_status;
         rsp_addr_ff   <= cmd.res_addr_ok ? run_addr : '0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/ffpra_chk.sv
// Port-level checks for the page run allocator, bound to the top level.
// Depends on ffpra_pkg and first_fit_page_run_allocator_top.
`default_nettype none

module ffpra_chk (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [ffpra_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]                        rsp_tuser
);
   import ffpra_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STAT_DONE) || (rsp_tuser == STAT_NOROOM) ||
                     (rsp_tuser == STAT_BAD))
      else $error("rsp status code out of range");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_DONE) |-> (rsp_tdata == '0))
      else $error("failed request returned a nonzero address");

   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

endmodule

bind first_fit_page_run_allocator_top ffpra_chk u_chk (.*);

`default_nettype wire
